// ===== design/sawarq_pkg.sv =====
// Package for the stop-and-wait ARQ sender: codes, phase type and queue command type.
// Depends on nothing; imported by every module of the block.
package sawarq_pkg;

  localparam int SEQ_W     = 32;
  localparam int LEN_W     = 10;
  localparam int LEN_EXT_W = 11;
  localparam int TRY_W     = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEN_W-1:0] HDR_BYTES  = 10'd12;
  localparam logic [LEN_W-1:0] INIT_EXTRA = 10'd13;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_CHUNK   = 3'd1;
  localparam logic [2:0] KIND_EOF     = 3'd2;
  localparam logic [2:0] KIND_REPLY   = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;
  localparam logic [2:0] KIND_REFUSED = 3'd5;

  localparam logic [7:0] RT_ACK      = 8'd1;
  localparam logic [7:0] RT_INIT_ACK = 8'd3;
  localparam logic [7:0] RT_STOP_ACK = 8'd5;

  localparam logic [2:0] PT_DATA        = 3'd0;
  localparam logic [2:0] PT_INIT        = 3'd2;
  localparam logic [2:0] PT_STOP        = 3'd4;
  localparam logic [2:0] PT_STOP_REALLY = 3'd6;

  localparam logic [1:0] EV_SEND     = 2'd0;
  localparam logic [1:0] EV_READY    = 2'd1;
  localparam logic [1:0] EV_FINISHED = 2'd2;
  localparam logic [1:0] EV_FAILED   = 2'd3;

  localparam logic [1:0] REG_INIT_TRY = 2'd0;
  localparam logic [1:0] REG_DATA_TRY = 2'd1;
  localparam logic [1:0] REG_STOP_TRY = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_INIT = 3'd1,
    PH_READY     = 3'd2,
    PH_WAIT_DATA = 3'd3,
    PH_WAIT_STOP = 3'd4,
    PH_DONE      = 3'd5,
    PH_FAILED    = 3'd6
  } phase_t;

  typedef struct packed {
    logic             two;
    logic [1:0]       ev;
    logic [2:0]       pt;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/sawarq_fifo.sv =====
// Short command queue between the front and back parts of the ARQ sender.
// Depends on sawarq_pkg for the command type and queue depth.
module sawarq_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sawarq_pkg::cmd_t wdata,
  input  logic             pop,
  output sawarq_pkg::cmd_t rdata,
  output sawarq_pkg::q_stat_t stat
);
  import sawarq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && stat.full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && stat.empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ===== design/sawarq_front.sv =====
// Front part of the ARQ sender: accepts events, keeps the protocol state and
// configuration, and queues one command per event that causes results. Uses sawarq_pkg.
module sawarq_front #(
  parameter int MAX_PACKET_BYTES = 548
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [5:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic [31:0]         in_start_seq,
  input  logic [9:0]          in_name_length,
  input  logic [9:0]          in_chunk_length,
  input  logic [7:0]          in_reply_type,
  input  logic [31:0]         in_reply_seq,
  input  sawarq_pkg::q_stat_t q_stat,
  output logic                q_push,
  output sawarq_pkg::cmd_t    q_cmd
);
  import sawarq_pkg::*;

  localparam logic [LEN_EXT_W-1:0] NAME_MAX  = LEN_EXT_W'(MAX_PACKET_BYTES - 13);
  localparam logic [LEN_EXT_W-1:0] CHUNK_MAX = LEN_EXT_W'(MAX_PACKET_BYTES - 12);

  phase_t           phase_r, phase_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [LEN_W-1:0] pend_r, pend_nxt;
  logic [LEN_W-1:0] init_len_r, init_len_nxt;
  logic [TRY_W-1:0] try_r, try_nxt;
  logic [TRY_W-1:0] init_lim_r, data_lim_r, stop_lim_r;

  logic             accept;
  logic             waiting;
  logic [TRY_W-1:0] lim;
  logic [LEN_W-1:0] nl_clamp, cl_clamp;
  logic [SEQ_W-1:0] ack_seq;
  cmd_t             resend;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign waiting  = (phase_r == PH_WAIT_INIT) || (phase_r == PH_WAIT_DATA) ||
                    (phase_r == PH_WAIT_STOP);
  assign nl_clamp = ({1'b0, in_name_length} > NAME_MAX) ? NAME_MAX[LEN_W-1:0]
                                                        : in_name_length;
  assign cl_clamp = ({1'b0, in_chunk_length} > CHUNK_MAX) ? CHUNK_MAX[LEN_W-1:0]
                                                          : in_chunk_length;
  assign ack_seq  = seq_r + {{(SEQ_W-LEN_W){1'b0}}, pend_r};

  always_comb begin
    case (phase_r)
      PH_WAIT_INIT: lim = init_lim_r;
      PH_WAIT_DATA: lim = data_lim_r;
      default:      lim = stop_lim_r;
    endcase
  end

  always_comb begin
    resend = '0;
    resend.ev  = EV_SEND;
    resend.seq = seq_r;
    case (phase_r)
      PH_WAIT_INIT: begin
        resend.pt  = PT_INIT;
        resend.len = init_len_r;
      end
      PH_WAIT_DATA: begin
        resend.pt  = PT_DATA;
        resend.len = pend_r + HDR_BYTES;
      end
      default: begin
        resend.pt  = PT_STOP;
        resend.len = HDR_BYTES;
      end
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    seq_nxt      = seq_r;
    pend_nxt     = pend_r;
    init_len_nxt = init_len_r;
    try_nxt      = try_r;
    q_push       = 1'b0;
    q_cmd        = '0;
    if (accept) begin
      case (in_kind)
        KIND_START: begin
          if ((phase_r == PH_IDLE) || (phase_r == PH_DONE) || (phase_r == PH_FAILED)) begin
            seq_nxt      = in_start_seq;
            init_len_nxt = nl_clamp + INIT_EXTRA;
            pend_nxt     = '0;
            try_nxt      = TRY_W'(1);
            phase_nxt    = PH_WAIT_INIT;
            q_push       = 1'b1;
            q_cmd.ev     = EV_SEND;
            q_cmd.pt     = PT_INIT;
            q_cmd.seq    = in_start_seq;
            q_cmd.len    = nl_clamp + INIT_EXTRA;
          end
        end
        KIND_CHUNK: begin
          if (phase_r == PH_READY) begin
            pend_nxt  = cl_clamp;
            try_nxt   = TRY_W'(1);
            phase_nxt = PH_WAIT_DATA;
            q_push    = 1'b1;
            q_cmd.ev  = EV_SEND;
            q_cmd.pt  = PT_DATA;
            q_cmd.seq = seq_r;
            q_cmd.len = cl_clamp + HDR_BYTES;
          end
        end
        KIND_EOF: begin
          if (phase_r == PH_READY) begin
            try_nxt   = TRY_W'(1);
            phase_nxt = PH_WAIT_STOP;
            q_push    = 1'b1;
            q_cmd.ev  = EV_SEND;
            q_cmd.pt  = PT_STOP;
            q_cmd.seq = seq_r;
            q_cmd.len = HDR_BYTES;
          end
        end
        KIND_REPLY: begin
          if ((phase_r == PH_WAIT_INIT) && (in_reply_type == RT_INIT_ACK) &&
              (in_reply_seq == seq_r)) begin
            phase_nxt = PH_READY;
            try_nxt   = '0;
            q_push    = 1'b1;
            q_cmd.ev  = EV_READY;
          end else if ((phase_r == PH_WAIT_DATA) && (in_reply_type == RT_ACK) &&
                       (in_reply_seq == ack_seq)) begin
            seq_nxt   = ack_seq;
            phase_nxt = PH_READY;
            try_nxt   = '0;
            q_push    = 1'b1;
            q_cmd.ev  = EV_READY;
          end else if ((phase_r == PH_WAIT_STOP) && (in_reply_type == RT_STOP_ACK) &&
                       (in_reply_seq == seq_r)) begin
            phase_nxt = PH_DONE;
            try_nxt   = '0;
            q_push    = 1'b1;
            q_cmd.two = 1'b1;
            q_cmd.ev  = EV_SEND;
            q_cmd.pt  = PT_STOP_REALLY;
            q_cmd.seq = seq_r;
            q_cmd.len = HDR_BYTES;
          end
        end
        KIND_TIMEOUT: begin
          if (waiting) begin
            q_push = 1'b1;
            if (try_r >= lim) begin
              phase_nxt = PH_FAILED;
              q_cmd.ev  = EV_FAILED;
            end else begin
              try_nxt = try_r + 1'b1;
              q_cmd   = resend;
            end
          end
        end
        KIND_REFUSED: begin
          if (waiting) begin
            phase_nxt = PH_FAILED;
            q_push    = 1'b1;
            q_cmd.ev  = EV_FAILED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      seq_r      <= '0;
      pend_r     <= '0;
      init_len_r <= '0;
      try_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      seq_r      <= seq_nxt;
      pend_r     <= pend_nxt;
      init_len_r <= init_len_nxt;
      try_r      <= try_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_lim_r <= TRY_W'(10);
      data_lim_r <= TRY_W'(30);
      stop_lim_r <= TRY_W'(30);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_TRY: init_lim_r <= cfg_wdata;
        REG_DATA_TRY: data_lim_r <= cfg_wdata;
        REG_STOP_TRY: stop_lim_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_try_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READY) |-> (try_r == '0))
    else $error("try count not cleared in ready phase");
  a_wait_try_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    waiting |-> (try_r != '0))
    else $error("try count zero while waiting for a reply");
  a_idle_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (seq_r == '0))
    else $error("sequence changed before any start");
`endif

endmodule

// ===== design/sawarq_back.sv =====
// Back part of the ARQ sender: drains queued commands into the registered
// result channel, expanding a two-result command. Uses sawarq_pkg.
module sawarq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sawarq_pkg::q_stat_t q_stat,
  input  sawarq_pkg::cmd_t    q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_event_res,
  output logic [2:0]          out_packet_type,
  output logic [31:0]         out_packet_seq,
  output logic [9:0]          out_packet_length,
  output logic                out_last
);
  import sawarq_pkg::*;

  logic             valid_r, valid_nxt;
  logic             second_r, second_nxt;
  logic             load;
  logic [1:0]       ev_r, ev_nxt;
  logic [2:0]       pt_r, pt_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             last_r, last_nxt;
  logic             advance;

  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt  = valid_r;
    second_nxt = second_r;
    ev_nxt     = ev_r;
    pt_nxt     = pt_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    last_nxt   = last_r;
    q_pop      = 1'b0;
    load       = 1'b0;
    if (advance) begin
      if (second_r) begin
        load       = 1'b1;
        valid_nxt  = 1'b1;
        second_nxt = 1'b0;
        ev_nxt     = EV_FINISHED;
        pt_nxt     = '0;
        seq_nxt    = '0;
        len_nxt    = '0;
        last_nxt   = 1'b1;
      end else if (!q_stat.empty) begin
        load       = 1'b1;
        q_pop      = 1'b1;
        valid_nxt  = 1'b1;
        second_nxt = q_cmd.two;
        ev_nxt     = q_cmd.ev;
        pt_nxt     = q_cmd.pt;
        seq_nxt    = q_cmd.seq;
        len_nxt    = q_cmd.len;
        last_nxt   = !q_cmd.two;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r   <= ev_nxt;
      pt_r   <= pt_nxt;
      seq_r  <= seq_nxt;
      len_r  <= len_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_event_res     = ev_r;
  assign out_packet_type   = pt_r;
  assign out_packet_seq    = seq_r;
  assign out_packet_length = len_r;
  assign out_last          = last_r;

`ifndef SYNTHESIS
  a_not_last_has_second: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !last_r) |-> second_r)
    else $error("non-final result without a following result");
  a_second_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> valid_r)
    else $error("pending second result while output empty");
  a_finished_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (ev_r == EV_FINISHED)) |-> (last_r && (pt_r == '0)))
    else $error("finished result malformed");
`endif

endmodule

// ===== design/stop_and_wait_arq_sender.sv =====
// Top level of the stop-and-wait ARQ sender protocol controller.
// Depends on sawarq_pkg, sawarq_front, sawarq_fifo and sawarq_back.
//
// Events enter on the in_ channel (valid/ready) and results leave on the out_
// channel (valid/ready); each result carries out_last on the final result of
// its event. Events that cause no result are absorbed without output.
// The cfg_ port writes the INIT, DATA and STOP try limits at index 0, 1 and 2.
// The front keeps the protocol state and classifies one event per cycle; it
// queues a command in a four-entry queue that the back drains into a
// registered output; a command passes through the queue and then the output
// register. Throughput is one event per cycle while the queue has room; the
// STOP_ACK event yields two results and so holds the output for both.
// When the receiver stalls, the output holds and the queue fills; in_ready
// drops only when the queue is full. Synchronous reset sets the idle phase,
// sequence zero, try limits 10, 30 and 30, and empties queue and output.
module stop_and_wait_arq_sender #(
  parameter int MAX_PACKET_BYTES = 548
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_start_seq,
  input  logic [9:0]  in_name_length,
  input  logic [9:0]  in_chunk_length,
  input  logic [7:0]  in_reply_type,
  input  logic [31:0] in_reply_seq,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [2:0]  out_packet_type,
  output logic [31:0] out_packet_seq,
  output logic [9:0]  out_packet_length,
  output logic        out_last
);
  import sawarq_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    q_push;
  logic    q_pop;

  sawarq_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_start_seq   (in_start_seq),
    .in_name_length (in_name_length),
    .in_chunk_length(in_chunk_length),
    .in_reply_type  (in_reply_type),
    .in_reply_seq   (in_reply_seq),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  sawarq_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(push_cmd),
    .pop  (q_pop),
    .rdata(head_cmd),
    .stat (q_stat)
  );

  sawarq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_packet_type  (out_packet_type),
    .out_packet_seq   (out_packet_seq),
    .out_packet_length(out_packet_length),
    .out_last         (out_last)
  );

endmodule

// ===== test/arq_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stop-and-wait ARQ sender: follows the protocol state from every accepted
// request and compares each accepted result with the oldest result still owed.
// Depends on sawarq_pkg; instantiated by tb_top beside the block.
module arq_checker #(
  parameter int MAX_PACKET_BYTES = 548
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_start_seq,
  input  logic [9:0]  in_name_length,
  input  logic [9:0]  in_chunk_length,
  input  logic [7:0]  in_reply_type,
  input  logic [31:0] in_reply_seq,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_event_res,
  input  logic [2:0]  out_packet_type,
  input  logic [31:0] out_packet_seq,
  input  logic [9:0]  out_packet_length,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);
  import sawarq_pkg::*;

  localparam logic [LEN_EXT_W-1:0] NAME_CAP  = LEN_EXT_W'(MAX_PACKET_BYTES - 13);
  localparam logic [LEN_EXT_W-1:0] CHUNK_CAP = LEN_EXT_W'(MAX_PACKET_BYTES - 12);

  typedef struct packed {
    logic [1:0]       ev;
    logic [2:0]       pt;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_t;

  result_t          owed_results[$];
  phase_t           link_phase;
  logic [SEQ_W-1:0] link_seq;
  logic [LEN_W-1:0] chunk_bytes;
  logic [LEN_W-1:0] init_bytes;
  logic [TRY_W-1:0] send_count;
  logic [TRY_W-1:0] cap_init;
  logic [TRY_W-1:0] cap_data;
  logic [TRY_W-1:0] cap_stop;

  task automatic report_mismatch(input string what);
    if (fail_count < 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  task automatic owe_result(input logic [1:0] ev, input logic [2:0] pt,
                            input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                            input logic last);
    result_t r;
    r = {ev, pt, seq, len, last};
    owed_results.push_back(r);
  endtask

  task automatic resend_pending();
    case (link_phase)
      PH_WAIT_INIT: owe_result(EV_SEND, PT_INIT, link_seq, init_bytes, 1'b1);
      PH_WAIT_DATA: owe_result(EV_SEND, PT_DATA, link_seq, chunk_bytes + HDR_BYTES, 1'b1);
      default:      owe_result(EV_SEND, PT_STOP, link_seq, HDR_BYTES, 1'b1);
    endcase
  endtask

  task automatic step_sender(input logic [2:0] kind, input logic [SEQ_W-1:0] sseq,
                             input logic [LEN_W-1:0] nlen, input logic [LEN_W-1:0] clen,
                             input logic [7:0] rtype, input logic [SEQ_W-1:0] rseq);
    logic             waiting;
    logic             closed;
    logic [TRY_W-1:0] cap;
    logic [SEQ_W-1:0] acked;
    waiting = link_phase == PH_WAIT_INIT || link_phase == PH_WAIT_DATA ||
              link_phase == PH_WAIT_STOP;
    closed = link_phase == PH_IDLE || link_phase == PH_DONE || link_phase == PH_FAILED;
    acked = link_seq + 32'(chunk_bytes);
    case (kind)
      KIND_START: begin
        if (closed) begin
          init_bytes = (({1'b0, nlen} > NAME_CAP) ? NAME_CAP[LEN_W-1:0] : nlen) +
                       INIT_EXTRA;
          link_seq = sseq;
          chunk_bytes = '0;
          send_count = TRY_W'(1);
          link_phase = PH_WAIT_INIT;
          resend_pending();
        end
      end
      KIND_CHUNK: begin
        if (link_phase == PH_READY) begin
          chunk_bytes = ({1'b0, clen} > CHUNK_CAP) ? CHUNK_CAP[LEN_W-1:0] : clen;
          send_count = TRY_W'(1);
          link_phase = PH_WAIT_DATA;
          resend_pending();
        end
      end
      KIND_EOF: begin
        if (link_phase == PH_READY) begin
          send_count = TRY_W'(1);
          link_phase = PH_WAIT_STOP;
          resend_pending();
        end
      end
      KIND_REPLY: begin
        if (link_phase == PH_WAIT_INIT && rtype == RT_INIT_ACK && rseq == link_seq) begin
          link_phase = PH_READY;
          send_count = '0;
          owe_result(EV_READY, '0, '0, '0, 1'b1);
        end else if (link_phase == PH_WAIT_DATA && rtype == RT_ACK && rseq == acked) begin
          link_seq = acked;
          link_phase = PH_READY;
          send_count = '0;
          owe_result(EV_READY, '0, '0, '0, 1'b1);
        end else if (link_phase == PH_WAIT_STOP && rtype == RT_STOP_ACK &&
                     rseq == link_seq) begin
          link_phase = PH_DONE;
          send_count = '0;
          owe_result(EV_SEND, PT_STOP_REALLY, link_seq, HDR_BYTES, 1'b0);
          owe_result(EV_FINISHED, '0, '0, '0, 1'b1);
        end
      end
      KIND_TIMEOUT: begin
        if (waiting) begin
          cap = (link_phase == PH_WAIT_INIT) ? cap_init :
                (link_phase == PH_WAIT_DATA) ? cap_data : cap_stop;
          if (send_count >= cap) begin
            link_phase = PH_FAILED;
            owe_result(EV_FAILED, '0, '0, '0, 1'b1);
          end else begin
            send_count = send_count + 1'b1;
            resend_pending();
          end
        end
      end
      KIND_REFUSED: begin
        if (waiting) begin
          link_phase = PH_FAILED;
          owe_result(EV_FAILED, '0, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = {out_event_res, out_packet_type, out_packet_seq, out_packet_length, out_last};
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result ev %0d type %0d seq %h len %0d with none owed",
                                got.ev, got.pt, got.seq, got.len));
    end else begin
      want = owed_results.pop_front();
      if (got.ev !== want.ev || got.pt !== want.pt || got.seq !== want.seq ||
          got.len !== want.len || got.last !== want.last) begin
        report_mismatch($sformatf(
          "got ev %0d type %0d seq %h len %0d last %0d, want ev %0d type %0d seq %h len %0d last %0d",
          got.ev, got.pt, got.seq, got.len, got.last,
          want.ev, want.pt, want.seq, want.len, want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      link_phase = PH_IDLE;
      link_seq = '0;
      chunk_bytes = '0;
      init_bytes = '0;
      send_count = '0;
      cap_init = 6'd10;
      cap_data = 6'd30;
      cap_stop = 6'd30;
      owed_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_TRY: cap_init = cfg_wdata;
          REG_DATA_TRY: cap_data = cfg_wdata;
          REG_STOP_TRY: cap_stop = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        step_sender(in_kind, in_start_seq, in_name_length, in_chunk_length,
                    in_reply_type, in_reply_seq);
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the stop-and-wait ARQ sender: clock, reset, try-limit writes,
// directed and random protocol requests, result pacing and the final verdict.
// Depends on sawarq_pkg, the block's RTL and arq_checker.
module tb_top;
  import sawarq_pkg::*;

  localparam int PKT_MAX        = 548;
  localparam int RANDOM_ITEMS   = 640;
  localparam int CFG_EVERY      = 120;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 500;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  typedef enum {AT_WAIT, AT_READY, AT_CLOSED} link_view_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] start_seq;
    logic [9:0]  name_length;
    logic [9:0]  chunk_length;
    logic [7:0]  reply_type;
    logic [31:0] reply_seq;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_start_seq = '0;
  logic [9:0]  in_name_length = '0;
  logic [9:0]  in_chunk_length = '0;
  logic [7:0]  in_reply_type = '0;
  logic [31:0] in_reply_seq = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_event_res;
  logic [2:0]  out_packet_type;
  logic [31:0] out_packet_seq;
  logic [9:0]  out_packet_length;
  logic        out_last;

  int          fail_count;
  int          pending;
  int          useful = 0;
  int          cfg_round = 0;
  int          lim_init = 10;
  int          lim_data = 30;
  int          lim_stop = 30;
  int          rx_hold = 0;
  logic [31:0] seq_now = '0;
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;

  stop_and_wait_arq_sender #(.MAX_PACKET_BYTES(PKT_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_start_seq(in_start_seq), .in_name_length(in_name_length),
    .in_chunk_length(in_chunk_length), .in_reply_type(in_reply_type),
    .in_reply_seq(in_reply_seq),
    .out_valid(out_valid), .out_ready(out_ready), .out_event_res(out_event_res),
    .out_packet_type(out_packet_type), .out_packet_seq(out_packet_seq),
    .out_packet_length(out_packet_length), .out_last(out_last)
  );

  arq_checker #(.MAX_PACKET_BYTES(PKT_MAX)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_start_seq(in_start_seq), .in_name_length(in_name_length),
    .in_chunk_length(in_chunk_length), .in_reply_type(in_reply_type),
    .in_reply_seq(in_reply_seq),
    .out_valid(out_valid), .out_ready(out_ready), .out_event_res(out_event_res),
    .out_packet_type(out_packet_type), .out_packet_seq(out_packet_seq),
    .out_packet_length(out_packet_length), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic request_t scrambled(input logic [2:0] kind);
    request_t r;
    r.kind = kind;
    r.start_seq = $urandom;
    r.name_length = 10'($urandom);
    r.chunk_length = 10'($urandom);
    r.reply_type = 8'($urandom);
    r.reply_seq = $urandom;
    return r;
  endfunction

  function automatic logic [5:0] pick_limit(input int round);
    case (round)
      0: return 6'd0;
      1: return 6'd63;
      2: return 6'd1;
      default: begin
        case ($urandom_range(0, 3))
          0: return 6'd1;
          1: return 6'd63;
          default: return 6'($urandom_range(1, 63));
        endcase
      end
    endcase
  endfunction

  task automatic push_request(input request_t r);
    int gap;
    if ($urandom_range(0, 40) == 0) tx_fast = !tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_start_seq <= r.start_seq;
    in_name_length <= r.name_length;
    in_chunk_length <= r.chunk_length;
    in_reply_type <= r.reply_type;
    in_reply_seq <= r.reply_seq;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic push_kind(input logic [2:0] kind);
    push_request(scrambled(kind));
  endtask

  task automatic push_reply(input logic [7:0] rtype, input logic [31:0] rseq);
    request_t r;
    r = scrambled(KIND_REPLY);
    r.reply_type = rtype;
    r.reply_seq = rseq;
    push_request(r);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [5:0] li, input logic [5:0] ld, input logic [5:0] ls);
    cfg_we <= 1'b1;
    cfg_index <= REG_INIT_TRY;
    cfg_wdata <= li;
    @(posedge clk);
    cfg_index <= REG_DATA_TRY;
    cfg_wdata <= ld;
    @(posedge clk);
    cfg_index <= REG_STOP_TRY;
    cfg_wdata <= ls;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_init = int'(li);
    lim_data = int'(ld);
    lim_stop = int'(ls);
  endtask

  // A noise request never changes the protocol state in the given view of the link.
  task automatic push_noise(input link_view_t where, input logic [7:0] good_type,
                            input logic [31:0] good_seq);
    int          pick;
    logic [7:0]  rt;
    logic [31:0] rs;
    pick = $urandom_range(0, 5);
    case (where)
      AT_WAIT: begin
        case (pick)
          0: push_kind(KIND_START);
          1: push_kind(KIND_CHUNK);
          2: push_kind(KIND_EOF);
          3: push_kind($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B);
          4: begin
            rt = 8'($urandom);
            if (rt == good_type) rt = ~rt;
            push_reply(rt, good_seq);
          end
          default: begin
            rs = $urandom_range(0, 1) ? good_seq ^ (32'd1 << $urandom_range(0, 31)) : $urandom;
            if (rs == good_seq) rs = ~rs;
            push_reply(good_type, rs);
          end
        endcase
      end
      AT_READY: begin
        case (pick)
          0: push_kind(KIND_START);
          1: push_kind(KIND_TIMEOUT);
          2: push_kind(KIND_REFUSED);
          3: push_kind($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B);
          default: push_kind(KIND_REPLY);
        endcase
      end
      default: begin
        case (pick)
          0: push_kind(KIND_CHUNK);
          1: push_kind(KIND_EOF);
          2: push_kind(KIND_REPLY);
          3: push_kind(KIND_TIMEOUT);
          4: push_kind(KIND_REFUSED);
          default: push_kind($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B);
        endcase
      end
    endcase
  endtask

  task automatic maybe_noise(input link_view_t where, input logic [7:0] good_type,
                             input logic [31:0] good_seq);
    while ($urandom_range(0, 3) == 0) push_noise(where, good_type, good_seq);
  endtask

  task automatic await_reply(input int lim, input logic [7:0] good_type,
                             input logic [31:0] good_seq, output bit alive);
    int cap;
    int roll;
    int n;
    cap = (lim == 0) ? 1 : lim;
    roll = $urandom_range(0, 19);
    n = (roll == 0) ? cap : $urandom_range(0, (cap > 3) ? 3 : cap - 1);
    repeat (n) begin
      maybe_noise(AT_WAIT, good_type, good_seq);
      push_kind(KIND_TIMEOUT);
      useful++;
    end
    alive = 1'b0;
    if (roll != 0) begin
      maybe_noise(AT_WAIT, good_type, good_seq);
      if (roll == 1) begin
        push_kind(KIND_REFUSED);
      end else begin
        push_reply(good_type, good_seq);
        alive = 1'b1;
      end
      useful++;
    end
  endtask

  task automatic run_session();
    request_t   r;
    bit         alive;
    int         chunks;
    logic [9:0] taken;
    r = scrambled(KIND_START);
    if ($urandom_range(0, 5) == 0) r.start_seq = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
    if ($urandom_range(0, 3) != 0) r.name_length = 10'($urandom_range(0, 535));
    seq_now = r.start_seq;
    push_request(r);
    useful++;
    await_reply(lim_init, RT_INIT_ACK, seq_now, alive);
    chunks = $urandom_range(0, 6);
    while (alive && chunks > 0) begin
      maybe_noise(AT_READY, '0, '0);
      r = scrambled(KIND_CHUNK);
      if ($urandom_range(0, 7) != 0) r.chunk_length = 10'($urandom_range(0, 536));
      taken = (r.chunk_length > PKT_MAX - 12) ? 10'(PKT_MAX - 12) : r.chunk_length;
      push_request(r);
      useful++;
      await_reply(lim_data, RT_ACK, seq_now + 32'(taken), alive);
      if (alive) seq_now = seq_now + 32'(taken);
      chunks--;
    end
    if (alive) begin
      maybe_noise(AT_READY, '0, '0);
      push_kind(KIND_EOF);
      useful++;
      await_reply(lim_stop, RT_STOP_ACK, seq_now, alive);
    end
  endtask

  always @(posedge clk) begin : result_pacing
    int hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (out_valid && out_ready) begin
      if ($urandom_range(0, 40) == 0) rx_fast = !rx_fast;
      hold = rx_fast ? 0 : $urandom_range(0, 10);
      rx_hold <= hold;
      out_ready <= (hold == 0);
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    request_t r;
    int       next_cfg;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_limits(6'd2, 6'd1, 6'd63);

    // Requests outside their phase, clamped lengths and sequence wrap.
    push_kind(KIND_REPLY);
    push_kind(KIND_TIMEOUT);
    r = scrambled(KIND_START);
    r.start_seq = 32'hFFFF_FFF0;
    r.name_length = 10'h3FF;
    push_request(r);
    push_kind(KIND_CHUNK);
    push_kind(KIND_TIMEOUT);
    push_reply(RT_INIT_ACK, 32'hFFFF_FFF1);
    push_reply(RT_INIT_ACK, 32'hFFFF_FFF0);
    push_kind(KIND_START);
    r = scrambled(KIND_CHUNK);
    r.chunk_length = 10'h3FF;
    push_request(r);
    push_reply(RT_ACK, 32'hFFFF_FFF0);
    push_reply(RT_ACK, 32'd520);
    r = scrambled(KIND_CHUNK);
    r.chunk_length = '0;
    push_request(r);
    push_reply(RT_ACK, 32'd520);
    push_kind(KIND_EOF);
    push_kind(KIND_TIMEOUT);
    push_reply(RT_STOP_ACK, 32'd520);
    push_kind(KIND_SPARE_A);
    push_kind(KIND_SPARE_B);

    // Try limits reached, refused, and a start from the failed phase.
    r = scrambled(KIND_START);
    r.start_seq = '0;
    r.name_length = '0;
    push_request(r);
    push_kind(KIND_TIMEOUT);
    push_kind(KIND_TIMEOUT);
    push_kind(KIND_START);
    push_kind(KIND_REFUSED);
    r = scrambled(KIND_START);
    r.start_seq = 32'hFFFF_FFFF;
    r.name_length = 10'd535;
    push_request(r);
    push_reply(RT_INIT_ACK, 32'hFFFF_FFFF);
    r = scrambled(KIND_CHUNK);
    r.chunk_length = 10'd536;
    push_request(r);
    push_kind(KIND_TIMEOUT);

    useful = 0;
    next_cfg = 0;
    while (useful < RANDOM_ITEMS) begin
      if (useful >= next_cfg) begin
        drain_block();
        set_limits(pick_limit(cfg_round), pick_limit(cfg_round), pick_limit(cfg_round));
        cfg_round++;
        next_cfg += CFG_EVERY;
      end
      maybe_noise(AT_CLOSED, '0, '0);
      run_session();
    end
    drain_block();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
